// ===== src/atpm_pkg.sv =====
// Shared types, codes and constants of the asset tracker page master.
`timescale 1ns / 1ps
package atpm_pkg;

	localparam int ASSET_SLOTS_DEF      = 32;
	localparam int DISCONNECT_PAGES_DEF = 5;

	localparam int IDX_W   = 5;
	localparam int LOC_W   = 96;  // {report, longitude, latitude}
	localparam int IDENT_W = 96;  // {name_second, name_first, kind, colour}

	// request actions
	localparam logic [2:0] ACT_CONNECT     = 3'd0;
	localparam logic [2:0] ACT_UPDATE      = 3'd1;
	localparam logic [2:0] ACT_DISC_ASSET  = 3'd2;
	localparam logic [2:0] ACT_REQ_IDENT   = 3'd3;
	localparam logic [2:0] ACT_BEGIN_DISC  = 3'd4;
	localparam logic [2:0] ACT_NEXT_PAGE   = 3'd5;

	// classified operations handed to the back end
	localparam logic [2:0] OP_CONNECT      = 3'd0;
	localparam logic [2:0] OP_UPDATE       = 3'd1;
	localparam logic [2:0] OP_DISC_ASSET   = 3'd2;
	localparam logic [2:0] OP_REQ_IDENT    = 3'd3;
	localparam logic [2:0] OP_BEGIN_DISC   = 3'd4;
	localparam logic [2:0] OP_NEXT_PAGE    = 3'd5;
	localparam logic [2:0] OP_RANGE_ERR    = 3'd6;
	localparam logic [2:0] OP_NOP          = 3'd7;

	// result codes
	localparam logic [1:0] RC_OK           = 2'd0;
	localparam logic [1:0] RC_RANGE        = 2'd1;
	localparam logic [1:0] RC_NOT_CONN     = 2'd2;

	// page numbers
	localparam logic [7:0] PG_LOC1 = 8'h01;
	localparam logic [7:0] PG_LOC2 = 8'h02;
	localparam logic [7:0] PG_NONE = 8'h03;
	localparam logic [7:0] PG_ID1  = 8'h10;
	localparam logic [7:0] PG_ID2  = 8'h11;
	localparam logic [7:0] PG_DISC = 8'h20;

	localparam logic [55:0] FILL_BYTES = 56'hFF_FFFF_FFFF_FFFF;
	localparam logic [2:0]  HEAD_MARK  = 3'b111;  // upper bits of byte 1, 0xE0

	typedef struct packed {
		logic [2:0]         op;
		logic [IDX_W-1:0]   idx;
		logic [LOC_W-1:0]   loc;
		logic [IDENT_W-1:0] ident;
	} cmd_t;

endpackage

// ===== src/atpm_ifs.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface atpm_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [4:0]         slot_index;
	logic [15:0]        distance;
	logic [7:0]         bearing;
	logic [7:0]         asset_status;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic [7:0]         colour;
	logic [7:0]         kind;
	logic [39:0]        name_first;
	logic [39:0]        name_second;

	modport source (output valid, action, slot_index, distance, bearing, asset_status,
		latitude, longitude, colour, kind, name_first, name_second, input ready);
	modport sink (input valid, action, slot_index, distance, bearing, asset_status,
		latitude, longitude, colour, kind, name_first, name_second, output ready);
endinterface

interface atpm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic        page_valid;
	logic [63:0] page_bytes;

	modport source (output valid, result_code, page_valid, page_bytes, input ready);
	modport sink (input valid, result_code, page_valid, page_bytes, output ready);
endinterface

// ===== src/asset_tracker_page_master.sv =====
// Top level of the asset tracker page master.
// A two-entry request queue sits in front of the executing back end, so the
// block keeps taking requests while a response waits. Control actions and
// disconnect and no-assets pages are executed directly from the idle state;
// a next-page request for an asset page first picks the asset and reads the
// asset table RAMs, then assembles the page in the form state. Each response
// then sits in the output register until taken, and the back end takes no
// new request while a response is held there.
`timescale 1ns / 1ps
module asset_tracker_page_master #(
	parameter int ASSET_SLOTS      = atpm_pkg::ASSET_SLOTS_DEF,
	parameter int DISCONNECT_PAGES = atpm_pkg::DISCONNECT_PAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	atpm_req_if.sink   req,
	atpm_rsp_if.source rsp
);
	import atpm_pkg::*;

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	atpm_front #(.ASSET_SLOTS(ASSET_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	atpm_back #(.ASSET_SLOTS(ASSET_SLOTS), .DISCONNECT_PAGES(DISCONNECT_PAGES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .rsp(rsp)
	);
endmodule

// ===== src/atpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module atpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/atpm_front.sv =====
// Front end: classifies requests and queues them for the back end.
`timescale 1ns / 1ps
module atpm_front #(
	parameter int ASSET_SLOTS = atpm_pkg::ASSET_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	atpm_req_if.sink       req,
	output logic           cmd_valid,
	output atpm_pkg::cmd_t cmd,
	input  logic           cmd_pop
);
	import atpm_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       in_range, push;

	// classify the incoming request
	always_comb begin
		in_range  = {1'b0, req.slot_index} < 6'(ASSET_SLOTS);
		cls.idx   = req.slot_index;
		cls.loc   = {req.asset_status, req.bearing, req.distance,
			req.longitude, req.latitude};
		cls.ident = {req.name_second, req.name_first, req.kind, req.colour};
		unique case (req.action)
			ACT_CONNECT:    cls.op = in_range ? OP_CONNECT : OP_RANGE_ERR;
			ACT_UPDATE:     cls.op = in_range ? OP_UPDATE : OP_RANGE_ERR;
			ACT_DISC_ASSET: cls.op = in_range ? OP_DISC_ASSET : OP_RANGE_ERR;
			ACT_REQ_IDENT:  cls.op = in_range ? OP_REQ_IDENT : OP_RANGE_ERR;
			ACT_BEGIN_DISC: cls.op = OP_BEGIN_DISC;
			ACT_NEXT_PAGE:  cls.op = OP_NEXT_PAGE;
			default:        cls.op = OP_NOP;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (cmd_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= cls;
	end
endmodule

// ===== src/atpm_back.sv =====
// Back end: asset table, rotation state and page assembly.
`timescale 1ns / 1ps
module atpm_back #(
	parameter int ASSET_SLOTS      = atpm_pkg::ASSET_SLOTS_DEF,
	parameter int DISCONNECT_PAGES = atpm_pkg::DISCONNECT_PAGES_DEF,
	localparam int AW = (ASSET_SLOTS > 1) ? $clog2(ASSET_SLOTS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  atpm_pkg::cmd_t cmd,
	output logic           cmd_pop,
	atpm_rsp_if.source     rsp
);
	import atpm_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FORM = 1'b1;

	logic                   st_q, st_d;
	logic [ASSET_SLOTS-1:0] conn_q, conn_d, pend_q, pend_d, upper;
	logic [AW-1:0]          ptr_q, ptr_d, idx_q, idx_d, sidx, pick;
	logic                   shd_q, shd_d;
	logic [2:0]             dcnt_q, dcnt_d;
	logic                   out_valid_q, load;
	logic [1:0]             code_q, code_d;
	logic                   pv_q, pv_d;
	logic [63:0]            pg_q, pg_d;
	logic                   loc_we, id_we;
	logic [LOC_W-1:0]       loc_rd;
	logic [IDENT_W-1:0]     id_rd;
	logic [7:0]             head;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
		return (s == AW'(ASSET_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [AW-1:0] first_set(input logic [ASSET_SLOTS-1:0] v);
		logic [AW-1:0] r;
		r = '0;
		for (int i = ASSET_SLOTS - 1; i >= 0; i--)
			if (v[i])
				r = AW'(i);
		return r;
	endfunction

	assign sidx = cmd.idx[AW-1:0];
	assign head = {HEAD_MARK, 5'(idx_q)};

	// round-robin pick: first connected slot at or after the pointer
	always_comb begin
		for (int i = 0; i < ASSET_SLOTS; i++)
			upper[i] = conn_q[i] && (32'(i) >= 32'(ptr_q));
		pick = (upper != '0) ? first_set(upper) : first_set(conn_q);
	end

	atpm_ram #(.WIDTH(LOC_W), .DEPTH(ASSET_SLOTS)) u_loc_ram (
		.clk(clk), .we(loc_we), .waddr(sidx), .wdata(cmd.loc),
		.raddr(pick), .rdata(loc_rd)
	);

	atpm_ram #(.WIDTH(IDENT_W), .DEPTH(ASSET_SLOTS)) u_id_ram (
		.clk(clk), .we(id_we), .waddr(sidx), .wdata(cmd.ident),
		.raddr(pick), .rdata(id_rd)
	);

	// command execution
	always_comb begin
		st_d    = st_q;
		conn_d  = conn_q;
		pend_d  = pend_q;
		ptr_d   = ptr_q;
		shd_d   = shd_q;
		dcnt_d  = dcnt_q;
		idx_d   = idx_q;
		cmd_pop = 1'b0;
		load    = 1'b0;
		loc_we  = 1'b0;
		id_we   = 1'b0;
		code_d  = RC_OK;
		pv_d    = 1'b0;
		pg_d    = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					cmd_pop = 1'b1;
					load    = 1'b1;
					case (cmd.op)
						OP_CONNECT: begin
							loc_we       = 1'b1;
							id_we        = 1'b1;
							conn_d[sidx] = 1'b1;
							pend_d[sidx] = 1'b1;
						end
						OP_UPDATE: begin
							if (conn_q[sidx])
								loc_we = 1'b1;
							else
								code_d = RC_NOT_CONN;
						end
						OP_DISC_ASSET: begin
							conn_d[sidx] = 1'b0;
							pend_d[sidx] = 1'b0;
							if (ptr_q == sidx) begin
								ptr_d = next_slot(sidx);
								shd_d = 1'b0;
							end
						end
						OP_REQ_IDENT: begin
							if (conn_q[sidx])
								pend_d[sidx] = 1'b1;
							else
								code_d = RC_NOT_CONN;
						end
						OP_BEGIN_DISC: dcnt_d = 3'(DISCONNECT_PAGES);
						OP_NEXT_PAGE: begin
							pv_d = 1'b1;
							if (dcnt_q != 3'd0) begin
								dcnt_d = dcnt_q - 3'd1;
								pg_d   = {FILL_BYTES, PG_DISC};
							end else if (conn_q == '0) begin
								pg_d = {FILL_BYTES, PG_NONE};
							end else begin
								// table read in flight, page formed next cycle
								load  = 1'b0;
								idx_d = pick;
								st_d  = ST_FORM;
							end
						end
						OP_RANGE_ERR: code_d = RC_RANGE;
						default: ;
					endcase
				end
			end
			ST_FORM: begin
				load = 1'b1;
				pv_d = 1'b1;
				st_d = ST_IDLE;
				if (pend_q[idx_q]) begin
					if (!shd_q) begin
						shd_d = 1'b1;
						pg_d  = {id_rd[55:16], id_rd[7:0], head, PG_ID1};
					end else begin
						shd_d         = 1'b0;
						pend_d[idx_q] = 1'b0;
						pg_d          = {id_rd[95:56], id_rd[15:8], head, PG_ID2};
					end
				end else if (!shd_q) begin
					shd_d = 1'b1;
					pg_d  = {loc_rd[15:0], loc_rd[95:64], head, PG_LOC1};
				end else begin
					shd_d = 1'b0;
					ptr_d = next_slot(idx_q);
					pg_d  = {loc_rd[63:32], loc_rd[31:16], head, PG_LOC2};
				end
			end
		endcase
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			conn_q      <= '0;
			pend_q      <= '0;
			ptr_q       <= '0;
			shd_q       <= 1'b0;
			dcnt_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			conn_q <= conn_d;
			pend_q <= pend_d;
			ptr_q  <= ptr_d;
			shd_q  <= shd_d;
			dcnt_q <= dcnt_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (load) begin
			code_q <= code_d;
			pv_q   <= pv_d;
			pg_q   <= pg_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_code = code_q;
	assign rsp.page_valid  = pv_q;
	assign rsp.page_bytes  = pg_q;
endmodule
